// ===== hw/rtl/range_min_segment_tree_macros.svh =====
// Assertion macros for the range-minimum tree.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef RANGE_MIN_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_SEGMENT_TREE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RMST_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`else
`define RMST_ASSERT(lbl, prop, msg)
`define RMST_ASSERT_IMPLY(lbl, cond, prop, msg)
`endif

`endif

// ===== hw/rtl/rmst_pkg.sv =====
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int SIZE_W           = 11;
  localparam int IDX_W            = 10;
  localparam int HI_W             = 11;
  localparam int VALUE_W          = 32;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Register indexes on the configuration port (word address).
  typedef enum logic [0:0] {
    REG_SIZE_IN_USE = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_UP,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    cmd_t                command;
    logic [IDX_W-1:0]    elem_index;
    value_t              elem_value;
    logic [IDX_W-1:0]    range_lo;
    logic [HI_W-1:0]     range_hi;
  } in_item_t;

  typedef struct packed {
    value_t min_value;
    logic   empty_range;
  } out_item_t;

  // Width that holds both the configured size and the tree capacity.
  function automatic int size_cmp_w(int max_elements);
    int w;
    w = $clog2(max_elements + 1);
    return (w > SIZE_W) ? w : SIZE_W;
  endfunction

  function automatic value_t min_val(value_t a, value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/rmst_mem.sv =====
`timescale 1ns / 1ps

module rmst_mem #(
  parameter int DEPTH = 2 * rmst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   wa,
  input  rmst_pkg::value_t           wd,
  input  logic [$clog2(DEPTH)-1:0]   ra,
  input  logic [$clog2(DEPTH)-1:0]   rb,
  output rmst_pkg::value_t           rd_a,
  output rmst_pkg::value_t           rd_b
);

  rmst_pkg::value_t mem_q [DEPTH];
  rmst_pkg::value_t rd_a_r;
  rmst_pkg::value_t rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_a_r <= mem_q[ra];
    rd_b_r <= mem_q[rb];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== hw/rtl/rmst_cfg.sv =====
`timescale 1ns / 1ps

module rmst_cfg #(
  parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [rmst_pkg::APB_ADDR_W-1:0]                 paddr,
  input  logic [rmst_pkg::APB_DATA_W-1:0]                 pwdata,
  output logic [rmst_pkg::APB_DATA_W-1:0]                 prdata,
  output logic                                            pready,
  output logic [rmst_pkg::size_cmp_w(MAX_ELEMENTS)-1:0]   used_size
);

  localparam int SZ_W = rmst_pkg::size_cmp_w(MAX_ELEMENTS);
  localparam logic [SZ_W-1:0] USED_RESET =
    (SZ_W'(rmst_pkg::SIZE_RESET) > SZ_W'(MAX_ELEMENTS)) ? SZ_W'(MAX_ELEMENTS)
                                                        : SZ_W'(rmst_pkg::SIZE_RESET);

  logic [rmst_pkg::SIZE_W-1:0] size_r;
  logic [rmst_pkg::SIZE_W-1:0] size_nxt;
  logic [SZ_W-1:0]             used_r;
  logic [SZ_W-1:0]             used_nxt;
  logic [SZ_W-1:0]             size_ext;
  rmst_pkg::reg_idx_t          reg_sel;

  assign reg_sel = rmst_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    size_nxt = size_r;
    if (psel && penable && pwrite && reg_sel == rmst_pkg::REG_SIZE_IN_USE) begin
      size_nxt = pwdata[rmst_pkg::SIZE_W-1:0];
    end
    // A size above the tree capacity behaves as the capacity.
    size_ext = SZ_W'(size_nxt);
    used_nxt = (size_ext > SZ_W'(MAX_ELEMENTS)) ? SZ_W'(MAX_ELEMENTS) : size_ext;
  end

  always_comb begin
    unique case (reg_sel)
      rmst_pkg::REG_SIZE_IN_USE: prdata = rmst_pkg::APB_DATA_W'(size_r);
      rmst_pkg::REG_NONE:        prdata = '0;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= rmst_pkg::SIZE_RESET;
      used_r <= USED_RESET;
    end else begin
      size_r <= size_nxt;
      used_r <= used_nxt;
    end
  end

  assign used_size = used_r;

endmodule

// ===== hw/rtl/rmst_ctrl.sv =====
`timescale 1ns / 1ps
`include "range_min_segment_tree_macros.svh"

module rmst_ctrl #(
  parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic [rmst_pkg::size_cmp_w(MAX_ELEMENTS)-1:0]   used_size,
  input  logic                                            in_valid,
  output logic                                            in_stall,
  input  rmst_pkg::in_item_t                              in_data,
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output rmst_pkg::out_item_t                             out_data,
  output logic                                            mem_we,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0]               mem_wa,
  output rmst_pkg::value_t                                mem_wd,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0]               mem_ra,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0]               mem_rb,
  input  rmst_pkg::value_t                                mem_rd_a,
  input  rmst_pkg::value_t                                mem_rd_b
);

  localparam int SZ_W = rmst_pkg::size_cmp_w(MAX_ELEMENTS);
  localparam int AW   = $clog2(2 * MAX_ELEMENTS);
  localparam int NW   = AW + 1;
  localparam logic [AW-1:0] LAST_NODE = AW'(2 * MAX_ELEMENTS - 1);
  localparam logic [AW-1:0] ROOT_NODE = AW'(1);

  rmst_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  rmst_pkg::value_t    cur_r, cur_nxt;
  logic [NW-1:0]       lo_r, lo_nxt;
  logic [NW-1:0]       hi_r, hi_nxt;
  rmst_pkg::value_t    best_r, best_nxt;
  logic                empty_r, empty_nxt;
  logic                rd_valid_r;
  logic                take_lo_r, take_hi_r;
  logic                pair_valid_r;
  rmst_pkg::value_t    pair_r;
  logic                out_valid_r, out_valid_nxt;
  rmst_pkg::out_item_t out_data_r, out_data_nxt;

  logic                accept;
  logic [SZ_W-1:0]     idx_ext, lo_ext, hi_ext, hi_clip;
  logic [NW-1:0]       leaf;
  logic [AW-1:0]       parent;
  rmst_pkg::value_t    up_min;
  rmst_pkg::value_t    a_eff, b_eff;
  logic [NW-1:0]       hi_m1;

  assign in_stall = (state_r != rmst_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign idx_ext = SZ_W'(in_data.elem_index);
  assign lo_ext  = SZ_W'(in_data.range_lo);
  assign hi_ext  = SZ_W'(in_data.range_hi);
  assign hi_clip = (hi_ext > used_size) ? used_size : hi_ext;
  assign leaf    = NW'(idx_ext) + NW'(MAX_ELEMENTS);
  assign parent  = node_r >> 1;
  assign up_min  = rmst_pkg::min_val(cur_r, mem_rd_a);
  assign hi_m1   = hi_r - NW'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    best_nxt      = best_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = rmst_pkg::VALUE_MAX;
    mem_ra        = lo_r[AW-1:0];
    mem_rb        = hi_m1[AW-1:0];

    if (pair_valid_r) begin
      best_nxt = rmst_pkg::min_val(best_r, pair_r);
    end

    unique case (state_r)
      rmst_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == rmst_pkg::CMD_WRITE) begin
            // Writes beyond the size in use are dropped.
            if (idx_ext < used_size) begin
              mem_we    = 1'b1;
              mem_wa    = leaf[AW-1:0];
              mem_wd    = in_data.elem_value;
              mem_ra    = leaf[AW-1:0] ^ AW'(1);
              node_nxt  = leaf[AW-1:0];
              cur_nxt   = in_data.elem_value;
              state_nxt = rmst_pkg::ST_WR_UP;
            end
          end else begin
            best_nxt = rmst_pkg::VALUE_MAX;
            if (lo_ext >= hi_clip) begin
              empty_nxt = 1'b1;
              state_nxt = rmst_pkg::ST_Q_DONE;
            end else begin
              empty_nxt = 1'b0;
              lo_nxt    = NW'(lo_ext) + NW'(MAX_ELEMENTS);
              hi_nxt    = NW'(hi_clip) + NW'(MAX_ELEMENTS);
              state_nxt = rmst_pkg::ST_Q_RUN;
            end
          end
        end
      end
      rmst_pkg::ST_WR_UP: begin
        // The sibling read last cycle is here; write the parent and fetch its sibling.
        mem_we   = 1'b1;
        mem_wa   = parent;
        mem_wd   = up_min;
        mem_ra   = parent ^ AW'(1);
        node_nxt = parent;
        cur_nxt  = up_min;
        if (parent == ROOT_NODE) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_Q_RUN: begin
        lo_nxt = (lo_r + NW'(lo_r[0])) >> 1;
        hi_nxt = hi_r >> 1;
        if (!(lo_nxt < hi_nxt)) begin
          state_nxt = rmst_pkg::ST_Q_DRAIN;
        end
      end
      rmst_pkg::ST_Q_DRAIN: begin
        if (!rd_valid_r && !pair_valid_r) begin
          state_nxt = rmst_pkg::ST_Q_DONE;
        end
      end
      rmst_pkg::ST_Q_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.min_value   = best_r;
          out_data_nxt.empty_range = empty_r;
          state_nxt                = rmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  assign a_eff = take_lo_r ? mem_rd_a : rmst_pkg::VALUE_MAX;
  assign b_eff = take_hi_r ? mem_rd_b : rmst_pkg::VALUE_MAX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rmst_pkg::ST_CLEAR;
      clr_r        <= '0;
      rd_valid_r   <= 1'b0;
      pair_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      rd_valid_r   <= (state_r == rmst_pkg::ST_Q_RUN);
      pair_valid_r <= rd_valid_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    best_r     <= best_nxt;
    empty_r    <= empty_nxt;
    take_lo_r  <= lo_r[0];
    take_hi_r  <= hi_r[0];
    pair_r     <= rmst_pkg::min_val(a_eff, b_eff);
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RMST_ASSERT_IMPLY(a_wr_rd_apart, state_r == rmst_pkg::ST_WR_UP, mem_wa != mem_ra, "parent write and sibling read hit the same node")
  `RMST_ASSERT_IMPLY(a_range_open, state_r == rmst_pkg::ST_Q_RUN, lo_r < hi_r, "query step with an exhausted range")
  `RMST_ASSERT_IMPLY(a_no_wr_in_query, state_r == rmst_pkg::ST_Q_RUN || state_r == rmst_pkg::ST_Q_DRAIN || state_r == rmst_pkg::ST_Q_DONE, !mem_we, "tree written during a query")
  `RMST_ASSERT_IMPLY(a_done_loads, $past(state_r) == rmst_pkg::ST_Q_DONE && state_r == rmst_pkg::ST_IDLE, out_valid_r, "query left without a result")

endmodule

// ===== hw/rtl/range_min_segment_tree.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload / ports                       | Handshake
// in_      | input     | in_data (rmst_pkg::in_item_t)         | in_valid / in_stall
// out_     | output    | out_data (rmst_pkg::out_item_t)       | out_valid / out_stall
// config   | input     | psel penable pwrite paddr pwdata      | pready always high
//
// After reset a clearing pass writes every tree node (2*MAX_ELEMENTS nodes, 2048 by
// default) before the first item is taken; register writes are taken meanwhile.
// A write updates one tree level per cycle, the leaf first and then each parent up to
// the root, through the single write port of the node memory; a dropped write stays idle.
// A query walks up to log2(MAX_ELEMENTS) + 1 levels at one per cycle on the two read
// ports; the reads then pass the memory read register, the pair stage and the final
// merge before the result is loaded; an empty query goes straight to the result load.
// A stalled result holds the next query at its end; writes still proceed.

module range_min_segment_tree #(
  parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rmst_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rmst_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmst_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmst_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmst_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int SZ_W  = rmst_pkg::size_cmp_w(MAX_ELEMENTS);
  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);

  logic [SZ_W-1:0]  used_size;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  rmst_pkg::value_t mem_wd;
  logic [AW-1:0]    mem_ra;
  logic [AW-1:0]    mem_rb;
  rmst_pkg::value_t mem_rd_a;
  rmst_pkg::value_t mem_rd_b;

  rmst_cfg #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .used_size (used_size)
  );

  rmst_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .wa   (mem_wa),
    .wd   (mem_wd),
    .ra   (mem_ra),
    .rb   (mem_rb),
    .rd_a (mem_rd_a),
    .rd_b (mem_rd_b)
  );

  rmst_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .used_size (used_size),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_ra    (mem_ra),
    .mem_rb    (mem_rb),
    .mem_rd_a  (mem_rd_a),
    .mem_rd_b  (mem_rd_b)
  );

endmodule
